// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms, clocked on clk and gated by rst_n
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define PSMF_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");
`define PSMF_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("forbidden condition seen");
`else
`define PSMF_ASSERT(lbl, prop)
`define PSMF_NEVER(lbl, expr)
`endif

`endif

// ===== rtl/psmf_pkg.sv =====
// ----------------------------------------------------------------------------
// psmf_pkg
// shared types, constants and the quarter-wave sine table of the tone mixer
// ----------------------------------------------------------------------------
`default_nettype none

package psmf_pkg;

  localparam int MAX_VOICES      = 16;
  localparam int SINE_TABLE_BITS = 10;
  localparam int DURATION_BITS   = 24;
  localparam int VIDX_W   = (MAX_VOICES > 1) ? $clog2(MAX_VOICES) : 1;
  localparam int CNT_W    = $clog2(MAX_VOICES + 1);
  localparam int PIPE_DEPTH = 8;
  localparam int PASS_LEN = MAX_VOICES + PIPE_DEPTH;
  localparam int PASS_W   = $clog2(PASS_LEN + 1);
  localparam int ACC_W    = 40;
  localparam int QB       = SINE_TABLE_BITS - 2;
  localparam int QN       = 1 << QB;

  localparam longint unsigned SIN_A1 = 64'd1686629713;
  localparam longint unsigned SIN_A3 = 64'd693598669;
  localparam longint unsigned SIN_A5 = 64'd85569306;
  localparam longint unsigned SIN_A7 = 64'd5026995;
  localparam longint unsigned SIN_A9 = 64'd172272;

  typedef enum logic [2:0] {
    CFG_CHANNELS = 3'd0,
    CFG_WIDTH    = 3'd1,
    CFG_SIGNED   = 3'd2,
    CFG_LITTLE   = 3'd3,
    CFG_EAR      = 3'd4
  } cfg_idx_t;

  typedef enum logic [2:0] {
    FADE_NONE   = 3'd0,
    FADE_IN     = 3'd1,
    FADE_OUT    = 3'd2,
    FADE_IN_OUT = 3'd3,
    FADE_OUT_IN = 3'd4
  } fade_t;

  typedef enum logic [1:0] {
    WSEL_8  = 2'd0,
    WSEL_16 = 2'd1,
    WSEL_32 = 2'd2
  } wsel_t;

  typedef struct packed {
    logic                     live;
    logic [31:0]              step;
    logic [DURATION_BITS-1:0] elapsed;
    logic [DURATION_BITS-1:0] length;
    logic [31:0]              inv;
    logic [31:0]              lgain;
    logic [31:0]              rgain;
    logic [31:0]              shift;
    logic [3:0]               shape;
  } voice_t;

  typedef logic [QN:0][14:0] qsin_t;

  function automatic qsin_t gen_qsin();
    qsin_t t;
    longint unsigned u, u2, p, m;
    for (int r = 0; r <= QN; r++) begin
      u  = longint'(r) << (30 - QB);
      u2 = (u * u) >> 30;
      p  = SIN_A9;
      p  = SIN_A7 - ((u2 * p) >> 30);
      p  = SIN_A5 - ((u2 * p) >> 30);
      p  = SIN_A3 - ((u2 * p) >> 30);
      p  = SIN_A1 - ((u2 * p) >> 30);
      m  = (((u * p) >> 30) + 64'd16384) >> 15;
      if (m > 64'd32767) m = 64'd32767;
      t[r] = m[14:0];
    end
    return t;
  endfunction

  localparam qsin_t QSIN = gen_qsin();

  // returns {negative, magnitude} for the top table bits of a phase
  function automatic logic [15:0] sine_lookup(input logic [31:0] phase);
    logic [SINE_TABLE_BITS-1:0] k;
    logic [1:0]                 quad;
    logic [QB:0]                idx;
    k    = phase[31 -: SINE_TABLE_BITS];
    quad = k[QB+1:QB];
    idx  = quad[0] ? ((QB+1)'(QN) - {1'b0, k[QB-1:0]}) : {1'b0, k[QB-1:0]};
    return {quad[1], QSIN[idx]};
  endfunction

endpackage

`default_nettype wire

// ===== rtl/psmf_if.sv =====
// ----------------------------------------------------------------------------
// psmf channel interfaces
// valid/ready channels carrying the input item and the result item
// ----------------------------------------------------------------------------
`default_nettype none

interface psmf_in_if;
  logic               valid;
  logic               ready;
  logic               kind;
  logic [31:0]        phase_step;
  logic [23:0]        duration_samples;
  logic [15:0]        amplitude;
  logic signed [15:0] azimuth_cosine;
  logic [2:0]         fade_mode;
  logic               waveform;

  modport source (output valid, kind, phase_step, duration_samples, amplitude,
                  azimuth_cosine, fade_mode, waveform, input ready);
  modport sink (input valid, kind, phase_step, duration_samples, amplitude,
                azimuth_cosine, fade_mode, waveform, output ready);
endinterface

interface psmf_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] left_code;
  logic [31:0] right_code;
  logic [4:0]  voice_count;
  logic        add_ok;

  modport source (output valid, left_code, right_code, voice_count, add_ok,
                  input ready);
  modport sink (input valid, left_code, right_code, voice_count, add_ok,
                output ready);
endinterface

`default_nettype wire

// ===== rtl/polyphonic_sine_mixer_with_fades.sv =====
// ----------------------------------------------------------------------------
// polyphonic_sine_mixer_with_fades
// voice table of tone voices mixed into packed left and right sample codes
// ----------------------------------------------------------------------------
// Voices live in a ring of 16 cells. A sample item rotates the ring once, one
// voice a cycle, through an 8-stage contribution pipeline into the accumulators,
// and the clamped and packed sums are then loaded into the output register.
// An add item runs the setup unit, whose 33-step divider computes 2^32/length;
// its result is loaded once the setup unit signals done.
// An add into a full table skips the setup unit and goes straight to the
// result state. A stalled result channel holds the sequencer in that state.
// One item is worked on at a time; the next item is taken while a result
// still waits in the output register.
`default_nettype none

`include "assert_macros.svh"

module polyphonic_sine_mixer_with_fades (
  input  wire logic  clk,
  input  wire logic  rst_n,
  psmf_in_if.sink    in_ch,
  psmf_out_if.source out_ch,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_wdata
);

  localparam int NV = psmf_pkg::MAX_VOICES;
  localparam int AW = psmf_pkg::ACC_W;
  localparam int CW = psmf_pkg::CNT_W;
  localparam int PW = psmf_pkg::PASS_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ADD,
    S_PASS,
    S_RESULT
  } state_t;

  // configuration
  logic [1:0]  ch_r, wsel_r;
  logic        sgn_r, le_r;
  logic [15:0] ear_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ch_r   <= 2'd2;
      wsel_r <= 2'd1;
      sgn_r  <= 1'b1;
      le_r   <= 1'b1;
      ear_r  <= 16'd2709;
    end else if (cfg_we) begin
      unique case (cfg_index)
        psmf_pkg::CFG_CHANNELS: ch_r   <= cfg_wdata[1:0];
        psmf_pkg::CFG_WIDTH:    wsel_r <= cfg_wdata[1:0];
        psmf_pkg::CFG_SIGNED:   sgn_r  <= cfg_wdata[0];
        psmf_pkg::CFG_LITTLE:   le_r   <= cfg_wdata[0];
        psmf_pkg::CFG_EAR:      ear_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  state_t         state_r;
  logic [PW-1:0]  pcnt_r;
  logic [CW-1:0]  count_r;
  logic           is_sample_r, ok_r;
  logic           out_valid_r;
  logic [31:0]    left_r, right_r;
  logic           add_ok_r;
  logic [4:0]     vcount_r;

  logic in_fire, shift, setup_done, full, retire, res_load;
  logic [NV-1:0] live_vec, load_vec;
  logic [psmf_pkg::VIDX_W-1:0] free_idx;
  psmf_pkg::voice_t cell_q   [NV];
  psmf_pkg::voice_t cell_nbr [NV];
  psmf_pkg::voice_t head_upd, new_rec;
  logic signed [AW-1:0] sum_l, sum_r;

  assign in_fire = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE);
  assign shift = (state_r == S_PASS) && (pcnt_r < PW'(NV));
  assign res_load = (state_r == S_RESULT) && (!out_valid_r || out_ch.ready);

  // ring head: advance or retire
  always_comb begin
    head_upd = cell_q[0];
    retire   = 1'b0;
    if (cell_q[0].live) begin
      if (cell_q[0].elapsed < cell_q[0].length) begin
        head_upd.elapsed = cell_q[0].elapsed + 1'b1;
      end else begin
        head_upd.live = 1'b0;
        retire        = 1'b1;
      end
    end
  end

  always_comb begin
    free_idx = '0;
    for (int i = NV - 1; i >= 0; i--) begin
      if (!live_vec[i]) free_idx = psmf_pkg::VIDX_W'(i);
    end
    full = &live_vec;
  end

  for (genvar i = 0; i < NV; i++) begin : g_ring
    if (i == NV - 1) begin : g_tail
      assign cell_nbr[i] = head_upd;
    end else begin : g_mid
      assign cell_nbr[i] = cell_q[i+1];
    end
    assign live_vec[i] = cell_q[i].live;
    assign load_vec[i] = setup_done && (free_idx == psmf_pkg::VIDX_W'(i));

    psmf_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .shift    (shift),
      .nbr      (cell_nbr[i]),
      .load     (load_vec[i]),
      .load_rec (new_rec),
      .rec      (cell_q[i])
    );
  end

  psmf_setup u_setup (
    .clk   (clk),
    .rst_n (rst_n),
    .start (in_fire && !in_ch.kind && !full),
    .step  (in_ch.phase_step),
    .dur   (in_ch.duration_samples),
    .amp   (in_ch.amplitude),
    .azc   (in_ch.azimuth_cosine),
    .fade  (in_ch.fade_mode),
    .wave  (in_ch.waveform),
    .ear   (ear_r),
    .done  (setup_done),
    .rec   (new_rec)
  );

  psmf_voice_pipe u_pipe (
    .clk   (clk),
    .rst_n (rst_n),
    .clear (in_fire && in_ch.kind),
    .feed  (shift),
    .rec   (cell_q[0]),
    .wsel  (wsel_r),
    .sum_l (sum_l),
    .sum_r (sum_r)
  );

  // clamp and pack
  function automatic logic signed [AW-1:0] clamp_to(input logic signed [AW-1:0] s,
                                                   input logic signed [AW-1:0] lim);
    if (s > lim)  return lim;
    if (s < -lim) return -lim;
    return s;
  endfunction

  function automatic logic [31:0] pack(input logic signed [AW-1:0] v,
                                       input logic [1:0] ws,
                                       input logic sg, input logic le);
    logic [31:0] b;
    b = v[31:0];
    unique case (ws)
      psmf_pkg::WSEL_16: begin
        b[31:16] = '0;
        if (!sg) b[15] = ~b[15];
        if (!le) b[15:0] = {b[7:0], b[15:8]};
      end
      psmf_pkg::WSEL_32: begin
        if (!sg) b[31] = ~b[31];
        if (!le) b = {b[7:0], b[15:8], b[23:16], b[31:24]};
      end
      default: begin
        b[31:8] = '0;
        if (!sg) b[7] = ~b[7];
      end
    endcase
    return b;
  endfunction

  logic signed [AW-1:0] lim, cl, cr, mono;
  logic signed [AW:0]   msum;
  logic [31:0]          lcode, rcode;

  always_comb begin
    unique case (wsel_r)
      psmf_pkg::WSEL_16: lim = AW'(32767);
      psmf_pkg::WSEL_32: lim = AW'(32'h7FFF_FFFF);
      default:           lim = AW'(127);
    endcase
    cl   = clamp_to(sum_l, lim);
    cr   = clamp_to(sum_r, lim);
    msum = {cl[AW-1], cl} + {cr[AW-1], cr};
    // halve with truncation toward zero
    msum = (msum + (AW+1)'(msum[AW])) >>> 1;
    mono = msum[AW-1:0];
    if (ch_r[1]) begin
      lcode = pack(cl, wsel_r, sgn_r, le_r);
      rcode = pack(cr, wsel_r, sgn_r, le_r);
    end else begin
      lcode = pack(mono, wsel_r, sgn_r, le_r);
      rcode = '0;
    end
  end

  // voice count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (setup_done) begin
      count_r <= count_r + 1'b1;
    end else if (shift && retire) begin
      count_r <= count_r - 1'b1;
    end
  end

  // sequencer and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pcnt_r      <= '0;
      is_sample_r <= 1'b0;
      ok_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (res_load)          out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            is_sample_r <= in_ch.kind;
            ok_r        <= 1'b0;
            pcnt_r      <= '0;
            if (in_ch.kind)  state_r <= S_PASS;
            else if (full)   state_r <= S_RESULT;
            else             state_r <= S_ADD;
          end
        end
        S_ADD: begin
          if (setup_done) begin
            ok_r    <= 1'b1;
            state_r <= S_RESULT;
          end
        end
        S_PASS: begin
          pcnt_r <= pcnt_r + 1'b1;
          if (pcnt_r == PW'(psmf_pkg::PASS_LEN - 1)) state_r <= S_RESULT;
        end
        S_RESULT: begin
          if (res_load) begin
            left_r      <= is_sample_r ? lcode : '0;
            right_r     <= is_sample_r ? rcode : '0;
            add_ok_r    <= ok_r;
            vcount_r    <= 5'(count_r);
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.left_code   = left_r;
  assign out_ch.right_code  = right_r;
  assign out_ch.voice_count = vcount_r;
  assign out_ch.add_ok      = add_ok_r;

  `PSMF_ASSERT(a_count_bound, count_r <= CW'(NV))
  `PSMF_ASSERT(a_count_live, (state_r == S_IDLE) |-> (int'(count_r) == $countones(live_vec)))
  `PSMF_NEVER(a_done_only_add, setup_done && (state_r != S_ADD))
  `PSMF_ASSERT(a_shift_drained, $fell(shift) |-> (state_r == S_PASS))

endmodule

`default_nettype wire

// ===== rtl/psmf_cell.sv =====
// ----------------------------------------------------------------------------
// psmf_cell
// one voice slot of the ring; takes its neighbor's record while shifting
// ----------------------------------------------------------------------------
`default_nettype none

module psmf_cell (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            shift,
  input  wire psmf_pkg::voice_t nbr,
  input  wire logic            load,
  input  wire psmf_pkg::voice_t load_rec,
  output psmf_pkg::voice_t     rec
);

  psmf_pkg::voice_t rec_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rec_r.live <= 1'b0;
    end else if (shift) begin
      rec_r <= nbr;
    end else if (load) begin
      rec_r <= load_rec;
    end
  end

  assign rec = rec_r;

endmodule

`default_nettype wire

// ===== rtl/psmf_setup.sv =====
// ----------------------------------------------------------------------------
// psmf_setup
// builds a new voice record: gains, ear phase offset and 2^32/length divider
// ----------------------------------------------------------------------------
`default_nettype none

module psmf_setup (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic [31:0]        step,
  input  wire logic [23:0]        dur,
  input  wire logic [15:0]        amp,
  input  wire logic signed [15:0] azc,
  input  wire logic [2:0]         fade,
  input  wire logic               wave,
  input  wire logic [15:0]        ear,
  output logic                    done,
  output psmf_pkg::voice_t        rec
);

  localparam int DW = psmf_pkg::DURATION_BITS;

  logic              busy_r;
  logic [5:0]        cnt_r;
  logic              done_r;
  logic [31:0]       step_r;
  logic [DW-1:0]     len_r;
  logic [15:0]       amp_r;
  logic signed [15:0] c_r;
  logic [16:0]       mag_r;
  logic [3:0]        shape_r;
  logic [DW-1:0]     rem_r;
  logic [32:0]       q_r;
  logic [31:0]       d_r;
  logic [47:0]       plo_r;
  logic [47:0]       phi_r;
  logic [31:0]       lg_r;
  logic [31:0]       rg_r;
  logic [31:0]       shift_r;

  logic [DW:0]   rem_sh;
  logic          take;
  logic [16:0]   wl, wr;
  logic [32:0]   lprod, rprod;
  logic [32:0]   dprod;
  logic [63:0]   dsum;
  logic [31:0]   sh;

  always_comb begin
    rem_sh = {rem_r, (cnt_r == 6'd0)};
    take   = rem_sh >= {1'b0, len_r};
    wl     = 17'h08000 - 17'(c_r);
    wr     = 17'h08000 + 17'(c_r);
    lprod  = {17'b0, amp_r} * {16'b0, wl};
    rprod  = {17'b0, amp_r} * {16'b0, wr};
    dprod  = {17'b0, ear} * {16'b0, mag_r};
    dsum   = {16'b0, plo_r} + {phi_r, 16'b0};
    sh     = dsum[54:23];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == 6'd32);
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == 6'd32) busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      step_r  <= step;
      len_r   <= DW'(dur);
      amp_r   <= (amp > 16'h8000) ? 16'h8000 : amp;
      c_r     <= azc;
      mag_r   <= azc[15] ? (17'd0 - 17'(azc)) : 17'(azc);
      shape_r <= {wave, fade};
      rem_r   <= '0;
      q_r     <= '0;
    end else if (busy_r) begin
      rem_r <= take ? DW'(rem_sh - {1'b0, len_r}) : DW'(rem_sh);
      q_r   <= {q_r[31:0], take};
      if (cnt_r == 6'd0) begin
        d_r  <= dprod[31:0];
        lg_r <= lprod[32:1];
        rg_r <= rprod[32:1];
      end
      if (cnt_r == 6'd1) plo_r <= d_r * {16'b0, step_r[15:0]};
      if (cnt_r == 6'd2) phi_r <= d_r * {16'b0, step_r[31:16]};
      if (cnt_r == 6'd3) shift_r <= c_r[15] ? (32'd0 - sh) : sh;
    end
  end

  always_comb begin
    rec.live    = 1'b1;
    rec.step    = step_r;
    rec.elapsed = '0;
    rec.length  = len_r;
    rec.inv     = ((len_r == '0) || q_r[32]) ? 32'hFFFF_FFFF : q_r[31:0];
    rec.lgain   = lg_r;
    rec.rgain   = rg_r;
    rec.shift   = shift_r;
    rec.shape   = shape_r;
  end

  assign done = done_r;

endmodule

`default_nettype wire

// ===== rtl/psmf_voice_pipe.sv =====
// ----------------------------------------------------------------------------
// psmf_voice_pipe
// per-voice contribution pipeline fed from the ring head, with accumulators
// ----------------------------------------------------------------------------
`default_nettype none

module psmf_voice_pipe (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      clear,
  input  wire logic                      feed,
  input  wire psmf_pkg::voice_t          rec,
  input  wire logic [1:0]                wsel,
  output logic signed [psmf_pkg::ACC_W-1:0] sum_l,
  output logic signed [psmf_pkg::ACC_W-1:0] sum_r
);

  localparam int DW = psmf_pkg::DURATION_BITS;
  localparam int AW = psmf_pkg::ACC_W;

  // stage 1
  logic [DW:0]   x_c;
  logic          none_c;
  logic [DW:0]   e2, len1;
  logic [DW+31:0] bprod;
  logic          v1_r, none1_r;
  logic [DW:0]   x1_r;
  logic [31:0]   base1_r, shift1_r, inv1_r, lg1_r, rg1_r;

  always_comb begin
    e2     = {rec.elapsed, 1'b0};
    len1   = {1'b0, rec.length};
    none_c = 1'b0;
    unique case (rec.shape[2:0])
      psmf_pkg::FADE_IN:     x_c = {1'b0, rec.elapsed};
      psmf_pkg::FADE_OUT:    x_c = {1'b0, rec.length - rec.elapsed};
      psmf_pkg::FADE_IN_OUT: x_c = (e2 < len1) ? e2 : {rec.length - rec.elapsed, 1'b0};
      psmf_pkg::FADE_OUT_IN: x_c = (e2 < len1) ? (len1 - e2) : (e2 - len1);
      default: begin
        x_c    = '0;
        none_c = 1'b1;
      end
    endcase
    bprod = {{DW{1'b0}}, rec.step} * {32'b0, rec.elapsed};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= feed && rec.live && (rec.elapsed < rec.length) && !rec.shape[3];
    end
    x1_r     <= x_c;
    none1_r  <= none_c;
    base1_r  <= bprod[31:0];
    shift1_r <= rec.shift;
    inv1_r   <= rec.inv;
    lg1_r    <= rec.lgain;
    rg1_r    <= rec.rgain;
  end

  // stage 2: fade fraction and table sine
  logic [DW+32:0] fprod;
  logic [16:0]    f_c;
  logic [15:0]    sl_c, sr_c;
  logic           v2_r;
  logic [16:0]    f2_r;
  logic [15:0]    sl2_r, sr2_r;
  logic [31:0]    lg2_r, rg2_r;

  always_comb begin
    fprod = {32'b0, x1_r} * {{(DW+1){1'b0}}, inv1_r};
    if (none1_r || (fprod[DW+32:17] > (DW+16)'(32768))) begin
      f_c = 17'h08000;
    end else begin
      f_c = fprod[33:17];
    end
    sl_c = psmf_pkg::sine_lookup(base1_r + shift1_r);
    sr_c = psmf_pkg::sine_lookup(base1_r - shift1_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else        v2_r <= v1_r;
    f2_r  <= f_c;
    sl2_r <= sl_c;
    sr2_r <= sr_c;
    lg2_r <= lg1_r;
    rg2_r <= rg1_r;
  end

  // stage 3: squared fade
  logic [33:0] sq;
  logic        v3_r;
  logic [15:0] ff3_r;
  logic [15:0] sl3_r, sr3_r;
  logic [31:0] lg3_r, rg3_r;

  assign sq = f2_r * f2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v3_r <= 1'b0;
    else        v3_r <= v2_r;
    ff3_r <= sq[30:15];
    sl3_r <= sl2_r;
    sr3_r <= sr2_r;
    lg3_r <= lg2_r;
    rg3_r <= rg2_r;
  end

  // stage 4: sine magnitude times fade
  logic [30:0] ml_c, mr_c;
  logic        v4_r, nl4_r, nr4_r;
  logic [29:0] ml4_r, mr4_r;
  logic [31:0] lg4_r, rg4_r;

  assign ml_c = {16'b0, sl3_r[14:0]} * {15'b0, ff3_r};
  assign mr_c = {16'b0, sr3_r[14:0]} * {15'b0, ff3_r};

  always_ff @(posedge clk) begin
    if (!rst_n) v4_r <= 1'b0;
    else        v4_r <= v3_r;
    ml4_r <= ml_c[29:0];
    mr4_r <= mr_c[29:0];
    nl4_r <= sl3_r[15];
    nr4_r <= sr3_r[15];
    lg4_r <= lg3_r;
    rg4_r <= rg3_r;
  end

  // stage 5: gain partial products
  logic        v5_r, nl5_r, nr5_r;
  logic [45:0] al5_r, bl5_r, ar5_r, br5_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v5_r <= 1'b0;
    else        v5_r <= v4_r;
    al5_r <= {16'b0, ml4_r} * {30'b0, lg4_r[15:0]};
    bl5_r <= {16'b0, ml4_r} * {30'b0, lg4_r[31:16]};
    ar5_r <= {16'b0, mr4_r} * {30'b0, rg4_r[15:0]};
    br5_r <= {16'b0, mr4_r} * {30'b0, rg4_r[31:16]};
    nl5_r <= nl4_r;
    nr5_r <= nr4_r;
  end

  // stage 6: combine partial products
  logic [63:0] tl, tr;
  logic        v6_r, nl6_r, nr6_r;
  logic [32:0] ql6_r, qr6_r;

  assign tl = {18'b0, al5_r} + {2'b0, bl5_r, 16'b0};
  assign tr = {18'b0, ar5_r} + {2'b0, br5_r, 16'b0};

  always_ff @(posedge clk) begin
    if (!rst_n) v6_r <= 1'b0;
    else        v6_r <= v5_r;
    ql6_r <= tl[61:29];
    qr6_r <= tr[61:29];
    nl6_r <= nl5_r;
    nr6_r <= nr5_r;
  end

  // stage 7: scale to full scale, q * (2^k - 1) / 2^31
  logic [4:0]          k;
  logic [63:0]         sl64, sr64;
  logic signed [AW-1:0] cl_c, cr_c;
  logic                v7_r;
  logic signed [AW-1:0] cl7_r, cr7_r;

  always_comb begin
    unique case (wsel)
      psmf_pkg::WSEL_16: k = 5'd15;
      psmf_pkg::WSEL_32: k = 5'd31;
      default:           k = 5'd7;
    endcase
    sl64 = ({31'b0, ql6_r} << k) - {31'b0, ql6_r};
    sr64 = ({31'b0, qr6_r} << k) - {31'b0, qr6_r};
    cl_c = nl6_r ? -$signed(AW'(sl64[63:31])) : $signed(AW'(sl64[63:31]));
    cr_c = nr6_r ? -$signed(AW'(sr64[63:31])) : $signed(AW'(sr64[63:31]));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v7_r <= 1'b0;
    else        v7_r <= v6_r;
    cl7_r <= cl_c;
    cr7_r <= cr_c;
  end

  // accumulators
  logic signed [AW-1:0] accl_r, accr_r;

  always_ff @(posedge clk) begin
    if (clear) begin
      accl_r <= '0;
      accr_r <= '0;
    end else if (v7_r) begin
      accl_r <= accl_r + cl7_r;
      accr_r <= accr_r + cr7_r;
    end
  end

  assign sum_l = accl_r;
  assign sum_r = accr_r;

endmodule

`default_nettype wire
